FILE: rtl/core/tci_pkg.sv
// ----------------------------------------------------------------------------
// Triangle circle package
// Beat types and sizing constants shared by the triangle circle datapath.
// ----------------------------------------------------------------------------
package tci_pkg;

	typedef struct packed {
		logic        [15:0] element_index;
		logic signed [31:0] vertex_i_x;
		logic signed [31:0] vertex_i_y;
		logic signed [31:0] vertex_j_x;
		logic signed [31:0] vertex_j_y;
		logic signed [31:0] vertex_k_x;
		logic signed [31:0] vertex_k_y;
		logic        [30:0] side_i_length;
		logic        [30:0] side_j_length;
		logic        [30:0] side_k_length;
	} tci_in_t;

	typedef struct packed {
		logic        [15:0] result_index;
		logic               circum_valid;
		logic signed [31:0] circumcenter_x;
		logic signed [31:0] circumcenter_y;
		logic        [30:0] circum_radius;
		logic signed [63:0] doubled_area;
		logic               in_valid;
		logic signed [31:0] incenter_x;
		logic signed [31:0] incenter_y;
		logic signed [31:0] in_radius;
	} tci_out_t;

	localparam int DIV_NW = 100;
	localparam int DIV_DW = 68;
	localparam int DIV_QB = 34;
	localparam int DIV_RW = DIV_DW + DIV_QB;
	localparam int DIV_LAT = DIV_QB + 2;

	localparam int SQ_W = 64;
	localparam int SQ_RW = SQ_W / 2;
	localparam int SQ_LAT = SQ_W / 2;

	localparam int FRONT_LAT = 7;
	localparam int BACK_LAT = 3;
	localparam int PIPE_LAT = FRONT_LAT + DIV_LAT + BACK_LAT + SQ_LAT;

	localparam logic [DIV_QB:0] OFS_LIMIT = (DIV_QB+1)'(64'd8589934592);
	localparam logic [SQ_RW-1:0] RAD_MAX = 32'h7FFF_FFFF;

endpackage

FILE: rtl/core/tci_div.sv
// ----------------------------------------------------------------------------
// Pipelined rounding divider
// Restoring division, one quotient bit per stage, rounded half away from zero.
// The overflow flag is set when the quotient would not fit in DIV_QB bits.
// ----------------------------------------------------------------------------
module tci_div
	import tci_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic [DIV_QB:0]   quo,
	output logic              ovf
);

	logic [DIV_RW-1:0] rem_s [DIV_QB+1];
	logic [DIV_DW-1:0] den_s [DIV_QB+1];
	logic [DIV_QB-1:0] quo_s [DIV_QB+1];
	logic              ovf_s [DIV_QB+1];
	logic [DIV_RW-1:0] sub_w [DIV_QB];
	logic              ge_w  [DIV_QB];
	logic              half_w;

	always_comb begin
		for (int k = 0; k < DIV_QB; k++) begin
			sub_w[k] = DIV_RW'(den_s[k]) << (DIV_QB - 1 - k);
			ge_w[k]  = rem_s[k] >= sub_w[k];
		end
	end

	assign half_w = {rem_s[DIV_QB][DIV_DW-1:0], 1'b0} >= {1'b0, den_s[DIV_QB]};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DIV_RW'(num);
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= DIV_RW'(num) >= {den, {DIV_QB{1'b0}}};
			for (int k = 0; k < DIV_QB; k++) begin
				rem_s[k+1] <= ge_w[k] ? rem_s[k] - sub_w[k] : rem_s[k];
				den_s[k+1] <= den_s[k];
				quo_s[k+1] <= quo_s[k] | (DIV_QB'(ge_w[k]) << (DIV_QB - 1 - k));
				ovf_s[k+1] <= ovf_s[k];
			end
			quo <= {1'b0, quo_s[DIV_QB]} + (DIV_QB+1)'(half_w);
			ovf <= ovf_s[DIV_QB];
		end
	end

endmodule

FILE: rtl/core/tci_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor of the square root of an unsigned word, one result bit per stage.
// ----------------------------------------------------------------------------
module tci_sqrt
	import tci_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [SQ_W-1:0]  val,
	output logic [SQ_RW-1:0] root
);

	logic [SQ_W-1:0] n_s   [SQ_LAT];
	logic [SQ_W-1:0] r_s   [SQ_LAT];
	logic [SQ_W-1:0] n_in  [SQ_LAT];
	logic [SQ_W-1:0] r_in  [SQ_LAT];
	logic [SQ_W-1:0] bit_w [SQ_LAT];
	logic [SQ_W-1:0] t_w   [SQ_LAT];
	logic            ge_w  [SQ_LAT];

	always_comb begin
		n_in[0] = val;
		r_in[0] = '0;
		for (int k = 1; k < SQ_LAT; k++) begin
			n_in[k] = n_s[k-1];
			r_in[k] = r_s[k-1];
		end
		for (int k = 0; k < SQ_LAT; k++) begin
			bit_w[k] = SQ_W'(1) << (SQ_W - 2 - 2 * k);
			t_w[k]   = r_in[k] + bit_w[k];
			ge_w[k]  = n_in[k] >= t_w[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SQ_LAT; k++) begin
				n_s[k] <= ge_w[k] ? n_in[k] - t_w[k] : n_in[k];
				r_s[k] <= ge_w[k] ? (r_in[k] >> 1) + bit_w[k] : r_in[k] >> 1;
			end
		end
	end

	assign root = r_s[SQ_LAT-1][SQ_RW-1:0];

endmodule

FILE: rtl/core/triangle_circumcircle_incircle.sv
// ----------------------------------------------------------------------------
// Triangle circumcircle and incircle
// Circumcentre, circumradius, doubled area, incentre and inradius of a
// triangle given its vertices and side lengths.
// ----------------------------------------------------------------------------
// The tri channel takes one triangle per beat and the res channel returns one
// result beat per triangle, in order. A beat moves at a rising edge where
// valid is high and stall is low on that channel.
// From its accepting edge to the edge at which its result first shows on res,
// every triangle passes through seven front stages of products and sums, a
// 36 stage pipelined divider, three stages for centre and squared radius, a
// 32 stage square root and the output register. One triangle can enter in
// every cycle while tri is not stalled; the throughput is then one beat per cycle.
// When res is stalled the result beat holds in the output register and the
// pipeline keeps moving until its last stage is full; only then is tri
// stalled, so no beat is lost or repeated.
// Reset clears the valid bits of all stages and of the output register; no
// clearing sweep is needed and a triangle can be taken at the first edge
// after reset is released.
// ----------------------------------------------------------------------------
module triangle_circumcircle_incircle
	import tci_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     tri_valid,
	output logic     tri_stall,
	input  tci_in_t  tri_data,
	output logic     res_valid,
	input  logic     res_stall,
	output tci_out_t res_data
);

	typedef struct packed {
		logic        [15:0] tag;
		logic signed [31:0] xi;
		logic signed [31:0] yi;
		logic        [66:0] dmag;
		logic               dneg;
		logic               cval;
		logic signed [63:0] area;
		logic        [63:0] nsxm;
		logic               nsxneg;
		logic        [63:0] nsym;
		logic               nsyneg;
		logic        [32:0] per;
		logic               ival;
	} front_t;

	typedef struct packed {
		logic        [15:0] tag;
		logic signed [31:0] xi;
		logic signed [31:0] yi;
		logic               cval;
		logic               ival;
		logic signed [63:0] area;
		logic               nxneg;
		logic               nyneg;
		logic               nsxneg;
		logic               nsyneg;
		logic               dneg;
	} div_side_t;

	typedef struct packed {
		logic        [15:0] tag;
		logic               cval;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic               radsat;
		logic signed [63:0] area;
		logic               ival;
		logic signed [31:0] inx;
		logic signed [31:0] iny;
		logic signed [31:0] inr;
	} sq_side_t;

	function automatic logic signed [63:0] sat64(input logic signed [66:0] v);
		logic signed [63:0] r;
		if (v[66:63] == 4'b0000 || v[66:63] == 4'b1111) begin
			r = v[63:0];
		end else if (v[66]) begin
			r = {1'b1, 63'd0};
		end else begin
			r = {1'b0, {63{1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
			r = v[31:0];
		end else if (v[35]) begin
			r = {1'b1, 31'd0};
		end else begin
			r = {1'b0, {31{1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [31:0] satq32(input logic [DIV_QB:0] q, input logic ovf,
		input logic neg);
		logic signed [31:0] r;
		if (neg) begin
			if (ovf || q > (DIV_QB+1)'(64'h8000_0000)) begin
				r = {1'b1, 31'd0};
			end else begin
				r = -$signed(q[31:0]);
			end
		end else begin
			if (ovf || q > (DIV_QB+1)'(64'h7FFF_FFFF)) begin
				r = {1'b0, {31{1'b1}}};
			end else begin
				r = $signed(q[31:0]);
			end
		end
		return r;
	endfunction

	logic                en;
	logic [PIPE_LAT-1:0] pv_q;
	logic                res_valid_q;
	tci_out_t            res_q;

	// Front stages.
	tci_in_t            d_s1, d_s2, d_s3;
	logic signed [32:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic signed [32:0] ax_s2, ay_s2, bx_s2, by_s2;
	logic signed [32:0] ax_s3, ay_s3, bx_s3, by_s3;
	logic        [32:0] per_s1, per_s2, per_s3;
	logic signed [65:0] axby_s2, aybx_s2;
	logic signed [65:0] sqax_w, sqay_w, sqbx_w, sqby_w;
	logic        [63:0] sqax_s2, sqay_s2, sqbx_s2, sqby_s2;
	logic signed [62:0] pxi_s2, pxj_s2, pxk_s2, pyi_s2, pyj_s2, pyk_s2;
	logic signed [66:0] det_s3;
	logic        [64:0] a2_s3, b2_s3;
	logic signed [64:0] nsx_s3, nsy_s3;
	logic signed [66:0] pa_s4, pb_s4, pc_s4, pd_s4, pe_s4, pf_s4, pg_s4, ph_s4;
	front_t             front_s4, front_s5, front_s6, front_s7;
	logic signed [67:0] nxh_s5, nxl_s5, nyh_s5, nyl_s5;
	logic signed [99:0] nx_s6, ny_s6;
	logic        [99:0] nxm_s7, nym_s7;
	logic               nxneg_s7, nyneg_s7;

	// Divider results and their side data.
	logic [DIV_QB:0] qox, qoy, qix, qiy, qir;
	logic            vox, voy, vix, viy, vir;
	div_side_t       div_side_q [DIV_LAT];
	div_side_t       ds;

	// Back stages.
	div_side_t          side_s8;
	logic        [33:0] oxm_s8, oym_s8;
	logic signed [31:0] inx_s8, iny_s8, inr_s8;
	logic signed [34:0] ox_w, oy_w;
	logic signed [35:0] cxs_w, cys_w;
	logic        [15:0] tag_s9, tag_s10;
	logic               cval_s9, cval_s10, ival_s9, ival_s10;
	logic signed [63:0] area_s9, area_s10;
	logic signed [31:0] cx_s9, cy_s9, cx_s10, cy_s10;
	logic signed [31:0] inx_s9, iny_s9, inr_s9, inx_s10, iny_s10, inr_s10;
	logic               radsat_s9, radsat_s10;
	logic        [61:0] sqx_s9, sqy_s9;
	logic        [62:0] sq_s10;
	sq_side_t           sq_side_q [SQ_LAT];
	sq_side_t           ts;
	logic [SQ_RW-1:0]   root;

	assign en        = !pv_q[PIPE_LAT-1] || !res_valid_q || !res_stall;
	assign tri_stall = !en;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (en) begin
				pv_q <= {pv_q[PIPE_LAT-2:0], tri_valid};
			end
			if (!res_valid_q || !res_stall) begin
				res_valid_q <= pv_q[PIPE_LAT-1];
			end
		end
	end

	always_comb begin
		sqax_w = ax_s1 * ax_s1;
		sqay_w = ay_s1 * ay_s1;
		sqbx_w = bx_s1 * bx_s1;
		sqby_w = by_s1 * by_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1   <= tri_data;
			ax_s1  <= 33'(tri_data.vertex_j_x) - 33'(tri_data.vertex_i_x);
			ay_s1  <= 33'(tri_data.vertex_j_y) - 33'(tri_data.vertex_i_y);
			bx_s1  <= 33'(tri_data.vertex_k_x) - 33'(tri_data.vertex_i_x);
			by_s1  <= 33'(tri_data.vertex_k_y) - 33'(tri_data.vertex_i_y);
			per_s1 <= 33'(tri_data.side_i_length) + 33'(tri_data.side_j_length)
				+ 33'(tri_data.side_k_length);

			d_s2    <= d_s1;
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			bx_s2   <= bx_s1;
			by_s2   <= by_s1;
			per_s2  <= per_s1;
			axby_s2 <= ax_s1 * by_s1;
			aybx_s2 <= ay_s1 * bx_s1;
			sqax_s2 <= sqax_w[63:0];
			sqay_s2 <= sqay_w[63:0];
			sqbx_s2 <= sqbx_w[63:0];
			sqby_s2 <= sqby_w[63:0];
			pxi_s2  <= d_s1.vertex_i_x * $signed({1'b0, d_s1.side_i_length});
			pxj_s2  <= d_s1.vertex_j_x * $signed({1'b0, d_s1.side_j_length});
			pxk_s2  <= d_s1.vertex_k_x * $signed({1'b0, d_s1.side_k_length});
			pyi_s2  <= d_s1.vertex_i_y * $signed({1'b0, d_s1.side_i_length});
			pyj_s2  <= d_s1.vertex_j_y * $signed({1'b0, d_s1.side_j_length});
			pyk_s2  <= d_s1.vertex_k_y * $signed({1'b0, d_s1.side_k_length});

			d_s3   <= d_s2;
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			bx_s3  <= bx_s2;
			by_s3  <= by_s2;
			per_s3 <= per_s2;
			det_s3 <= 67'(axby_s2) - 67'(aybx_s2);
			a2_s3  <= 65'(sqax_s2) + 65'(sqay_s2);
			b2_s3  <= 65'(sqbx_s2) + 65'(sqby_s2);
			nsx_s3 <= 65'(pxi_s2) + 65'(pxj_s2) + 65'(pxk_s2);
			nsy_s3 <= 65'(pyi_s2) + 65'(pyj_s2) + 65'(pyk_s2);

			pa_s4 <= by_s3 * $signed({1'b0, a2_s3[32:0]});
			pb_s4 <= by_s3 * $signed({1'b0, a2_s3[64:33]});
			pc_s4 <= ay_s3 * $signed({1'b0, b2_s3[32:0]});
			pd_s4 <= ay_s3 * $signed({1'b0, b2_s3[64:33]});
			pe_s4 <= ax_s3 * $signed({1'b0, b2_s3[32:0]});
			pf_s4 <= ax_s3 * $signed({1'b0, b2_s3[64:33]});
			pg_s4 <= bx_s3 * $signed({1'b0, a2_s3[32:0]});
			ph_s4 <= bx_s3 * $signed({1'b0, a2_s3[64:33]});
			front_s4.tag    <= d_s3.element_index;
			front_s4.xi     <= d_s3.vertex_i_x;
			front_s4.yi     <= d_s3.vertex_i_y;
			front_s4.dmag   <= det_s3[66] ? 67'(-det_s3) : 67'(det_s3);
			front_s4.dneg   <= det_s3[66];
			front_s4.cval   <= !det_s3[66] && (det_s3 != '0);
			front_s4.area   <= sat64(det_s3);
			front_s4.nsxm   <= nsx_s3[64] ? 64'(-nsx_s3) : 64'(nsx_s3);
			front_s4.nsxneg <= nsx_s3[64];
			front_s4.nsym   <= nsy_s3[64] ? 64'(-nsy_s3) : 64'(nsy_s3);
			front_s4.nsyneg <= nsy_s3[64];
			front_s4.per    <= per_s3;
			front_s4.ival   <= per_s3 != '0;

			front_s5 <= front_s4;
			nxh_s5   <= 68'(pb_s4) - 68'(pd_s4);
			nxl_s5   <= 68'(pa_s4) - 68'(pc_s4);
			nyh_s5   <= 68'(pf_s4) - 68'(ph_s4);
			nyl_s5   <= 68'(pe_s4) - 68'(pg_s4);

			front_s6 <= front_s5;
			nx_s6    <= (100'(nxh_s5) <<< 33) + 100'(nxl_s5);
			ny_s6    <= (100'(nyh_s5) <<< 33) + 100'(nyl_s5);

			front_s7 <= front_s6;
			nxm_s7   <= nx_s6[99] ? 100'(-nx_s6) : 100'(nx_s6);
			nxneg_s7 <= nx_s6[99];
			nym_s7   <= ny_s6[99] ? 100'(-ny_s6) : 100'(ny_s6);
			nyneg_s7 <= ny_s6[99];
		end
	end

	tci_div u_div_ox (
		.clk (clk),
		.en  (en),
		.num (nxm_s7),
		.den ({front_s7.dmag, 1'b0}),
		.quo (qox),
		.ovf (vox)
	);

	tci_div u_div_oy (
		.clk (clk),
		.en  (en),
		.num (nym_s7),
		.den ({front_s7.dmag, 1'b0}),
		.quo (qoy),
		.ovf (voy)
	);

	tci_div u_div_ix (
		.clk (clk),
		.en  (en),
		.num (DIV_NW'(front_s7.nsxm)),
		.den (DIV_DW'(front_s7.per)),
		.quo (qix),
		.ovf (vix)
	);

	tci_div u_div_iy (
		.clk (clk),
		.en  (en),
		.num (DIV_NW'(front_s7.nsym)),
		.den (DIV_DW'(front_s7.per)),
		.quo (qiy),
		.ovf (viy)
	);

	tci_div u_div_ir (
		.clk (clk),
		.en  (en),
		.num (DIV_NW'(front_s7.dmag)),
		.den (DIV_DW'(front_s7.per)),
		.quo (qir),
		.ovf (vir)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			div_side_q[0].tag    <= front_s7.tag;
			div_side_q[0].xi     <= front_s7.xi;
			div_side_q[0].yi     <= front_s7.yi;
			div_side_q[0].cval   <= front_s7.cval;
			div_side_q[0].ival   <= front_s7.ival;
			div_side_q[0].area   <= front_s7.area;
			div_side_q[0].nxneg  <= nxneg_s7;
			div_side_q[0].nyneg  <= nyneg_s7;
			div_side_q[0].nsxneg <= front_s7.nsxneg;
			div_side_q[0].nsyneg <= front_s7.nsyneg;
			div_side_q[0].dneg   <= front_s7.dneg;
			for (int k = 1; k < DIV_LAT; k++) begin
				div_side_q[k] <= div_side_q[k-1];
			end
		end
	end

	assign ds = div_side_q[DIV_LAT-1];

	// Offsets beyond the clamp always saturate the centre, so they are held there.
	always_comb begin
		ox_w  = side_s8.nxneg ? -35'(oxm_s8) : 35'(oxm_s8);
		oy_w  = side_s8.nyneg ? -35'(oym_s8) : 35'(oym_s8);
		cxs_w = 36'(side_s8.xi) + 36'(ox_w);
		cys_w = 36'(side_s8.yi) + 36'(oy_w);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s8 <= ds;
			oxm_s8  <= (vox || qox > OFS_LIMIT) ? OFS_LIMIT[33:0] : qox[33:0];
			oym_s8  <= (voy || qoy > OFS_LIMIT) ? OFS_LIMIT[33:0] : qoy[33:0];
			inx_s8  <= ds.ival ? satq32(qix, vix, ds.nsxneg) : '0;
			iny_s8  <= ds.ival ? satq32(qiy, viy, ds.nsyneg) : '0;
			inr_s8  <= ds.ival ? satq32(qir, vir, ds.dneg) : '0;

			tag_s9    <= side_s8.tag;
			cval_s9   <= side_s8.cval;
			ival_s9   <= side_s8.ival;
			area_s9   <= side_s8.area;
			inx_s9    <= inx_s8;
			iny_s9    <= iny_s8;
			inr_s9    <= inr_s8;
			cx_s9     <= sat32(cxs_w);
			cy_s9     <= sat32(cys_w);
			radsat_s9 <= (oxm_s8 > 34'(RAD_MAX)) || (oym_s8 > 34'(RAD_MAX));
			sqx_s9    <= oxm_s8[30:0] * oxm_s8[30:0];
			sqy_s9    <= oym_s8[30:0] * oym_s8[30:0];

			tag_s10    <= tag_s9;
			cval_s10   <= cval_s9;
			ival_s10   <= ival_s9;
			area_s10   <= area_s9;
			inx_s10    <= inx_s9;
			iny_s10    <= iny_s9;
			inr_s10    <= inr_s9;
			cx_s10     <= cx_s9;
			cy_s10     <= cy_s9;
			radsat_s10 <= radsat_s9;
			sq_s10     <= 63'(sqx_s9) + 63'(sqy_s9);
		end
	end

	tci_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.val  (SQ_W'(sq_s10)),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_side_q[0].tag    <= tag_s10;
			sq_side_q[0].cval   <= cval_s10;
			sq_side_q[0].cx     <= cx_s10;
			sq_side_q[0].cy     <= cy_s10;
			sq_side_q[0].radsat <= radsat_s10;
			sq_side_q[0].area   <= area_s10;
			sq_side_q[0].ival   <= ival_s10;
			sq_side_q[0].inx    <= inx_s10;
			sq_side_q[0].iny    <= iny_s10;
			sq_side_q[0].inr    <= inr_s10;
			for (int k = 1; k < SQ_LAT; k++) begin
				sq_side_q[k] <= sq_side_q[k-1];
			end
		end
	end

	assign ts = sq_side_q[SQ_LAT-1];

	always_ff @(posedge clk) begin
		if (!res_valid_q || !res_stall) begin
			res_q.result_index   <= ts.tag;
			res_q.circum_valid   <= ts.cval;
			res_q.circumcenter_x <= ts.cval ? ts.cx : '0;
			res_q.circumcenter_y <= ts.cval ? ts.cy : '0;
			if (!ts.cval) begin
				res_q.circum_radius <= '0;
			end else if (ts.radsat || root > RAD_MAX) begin
				res_q.circum_radius <= RAD_MAX[30:0];
			end else begin
				res_q.circum_radius <= root[30:0];
			end
			res_q.doubled_area <= ts.area;
			res_q.in_valid     <= ts.ival;
			res_q.incenter_x   <= ts.inx;
			res_q.incenter_y   <= ts.iny;
			res_q.in_radius    <= ts.inr;
		end
	end

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		tri_stall |-> (pv_q[PIPE_LAT-1] && res_valid_q && res_stall))
		else $error("input stalled while the pipeline could advance");

	a_result_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(pv_q[PIPE_LAT-1]))
		else $error("result beat appeared without a finished triangle");

	a_circ_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.circum_valid) |-> (res_q.circumcenter_x == 0
		&& res_q.circumcenter_y == 0 && res_q.circum_radius == 0))
		else $error("circumcircle fields not cleared for a degenerate triangle");

	a_in_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.in_valid) |-> (res_q.incenter_x == 0
		&& res_q.incenter_y == 0 && res_q.in_radius == 0))
		else $error("incircle fields not cleared for a zero perimeter");

endmodule

FILE: dv/triangle_circumcircle_incircle_test.sv
// ----------------------------------------------------------------------------
// Triangle circumcircle and incircle testbench
// Sends triangles into the tri channel in bursts with random gaps. The
// receiver on the res channel stalls in changing patterns. Each accepted beat
// is predicted with exact wide integer arithmetic, and the predicted beats are
// compared in order with the result beats.
// ----------------------------------------------------------------------------
module triangle_circumcircle_incircle_test;
	import tci_pkg::*;

	typedef logic signed [127:0] wide_t;

	localparam int      N_RANDOM   = 1000;
	localparam int      PAUSE_AT   = 700;
	localparam int      HOLD_START = 400;
	localparam int      HOLD_LEN   = 500;
	localparam int      IDLE_LIMIT = 4000;
	localparam wide_t   I32_MAX    = 128'sd2147483647;
	localparam wide_t   I32_MIN    = -128'sd2147483648;
	localparam wide_t   I64_MAX    = {65'b0, {63{1'b1}}};
	localparam wide_t   I64_MIN    = -I64_MAX - 1;
	localparam wide_t   OFS_CLAMP  = 128'sd8589934592;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     tri_valid;
	logic     tri_stall;
	tci_in_t  tri_data;
	logic     res_valid;
	logic     res_stall;
	tci_out_t res_data;

	tci_in_t  pending_tris[$];
	tci_out_t expected_results[$];
	int       failures = 0;
	int       sent_count = 0;
	int       gap_left = 0;
	int       burst_left = 1;
	int       cycle_count = 0;
	int       idle_cycles = 0;
	int       stall_mode = 0;

	triangle_circumcircle_incircle dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tri_valid (tri_valid),
		.tri_stall (tri_stall),
		.tri_data  (tri_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	always #5 clk = ~clk;

	function automatic wide_t clamp(wide_t v, wide_t lo, wide_t hi);
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic wide_t div_nearest(wide_t n, wide_t d);
		wide_t mn;
		wide_t md;
		wide_t q;
		wide_t r;
		mn = (n < 0) ? -n : n;
		md = (d < 0) ? -d : d;
		q = mn / md;
		r = mn - q * md;
		if (2 * r >= md) q = q + 1;
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic wide_t floor_sqrt(wide_t n);
		wide_t r;
		wide_t t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (wide_t'(1) << b);
			if (t * t <= n) r = t;
		end
		return r;
	endfunction

	function automatic tci_out_t predict_circles(tci_in_t t);
		tci_out_t o;
		wide_t xi, yi, xj, yj, xk, yk, si, sj, sk;
		wide_t ax, ay, bx, by, det, a2, b2, nx, ny, ox, oy, ux, uy, per;
		xi = wide_t'(t.vertex_i_x);
		yi = wide_t'(t.vertex_i_y);
		xj = wide_t'(t.vertex_j_x);
		yj = wide_t'(t.vertex_j_y);
		xk = wide_t'(t.vertex_k_x);
		yk = wide_t'(t.vertex_k_y);
		si = {97'b0, t.side_i_length};
		sj = {97'b0, t.side_j_length};
		sk = {97'b0, t.side_k_length};
		ax = xj - xi;
		ay = yj - yi;
		bx = xk - xi;
		by = yk - yi;
		det = ax * by - ay * bx;
		o = '0;
		o.result_index = t.element_index;
		if (det > 0) begin
			a2 = ax * ax + ay * ay;
			b2 = bx * bx + by * by;
			nx = by * a2 - ay * b2;
			ny = ax * b2 - bx * a2;
			ox = clamp(div_nearest(nx, 2 * det), -OFS_CLAMP, OFS_CLAMP);
			oy = clamp(div_nearest(ny, 2 * det), -OFS_CLAMP, OFS_CLAMP);
			ux = (ox < 0) ? -ox : ox;
			uy = (oy < 0) ? -oy : oy;
			o.circum_valid = 1'b1;
			o.circumcenter_x = 32'(clamp(xi + ox, I32_MIN, I32_MAX));
			o.circumcenter_y = 32'(clamp(yi + oy, I32_MIN, I32_MAX));
			if (ux > I32_MAX || uy > I32_MAX)
				o.circum_radius = 31'h7FFF_FFFF;
			else
				o.circum_radius = 31'(clamp(floor_sqrt(ux * ux + uy * uy), 0, I32_MAX));
		end
		o.doubled_area = 64'(clamp(det, I64_MIN, I64_MAX));
		per = si + sj + sk;
		if (per != 0) begin
			o.in_valid = 1'b1;
			o.incenter_x = 32'(clamp(div_nearest(xi * si + xj * sj + xk * sk, per),
				I32_MIN, I32_MAX));
			o.incenter_y = 32'(clamp(div_nearest(yi * si + yj * sj + yk * sk, per),
				I32_MIN, I32_MAX));
			o.in_radius = 32'(clamp(div_nearest(det, per), I32_MIN, I32_MAX));
		end
		return o;
	endfunction

	function automatic tci_in_t make_tri(int xi, int yi, int xj, int yj, int xk, int yk,
			int si, int sj, int sk);
		tci_in_t t;
		t.element_index = 16'($urandom);
		t.vertex_i_x = xi;
		t.vertex_i_y = yi;
		t.vertex_j_x = xj;
		t.vertex_j_y = yj;
		t.vertex_k_x = xk;
		t.vertex_k_y = yk;
		t.side_i_length = 31'(si);
		t.side_j_length = 31'(sj);
		t.side_k_length = 31'(sk);
		return t;
	endfunction

	function automatic int scaled_coord(int shift);
		return $signed($urandom) >>> shift;
	endfunction

	function automatic tci_in_t random_tri();
		tci_in_t t;
		int mode;
		int sh;
		int cx;
		int cy;
		mode = $urandom_range(0, 9);
		t = make_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom);
		if (mode >= 2 && mode <= 7) begin
			sh = $urandom_range(8, 16);
			cx = scaled_coord(2);
			cy = scaled_coord(2);
			t.vertex_i_x = cx + scaled_coord(sh);
			t.vertex_i_y = cy + scaled_coord(sh);
			t.vertex_j_x = cx + scaled_coord(sh);
			t.vertex_j_y = cy + scaled_coord(sh);
			t.vertex_k_x = cx + scaled_coord(sh);
			t.vertex_k_y = cy + scaled_coord(sh);
			t.side_i_length = 31'($urandom) >> $urandom_range(4, 16);
			t.side_j_length = 31'($urandom) >> $urandom_range(4, 16);
			t.side_k_length = 31'($urandom) >> $urandom_range(4, 16);
		end else if (mode == 8) begin
			cx = scaled_coord(8);
			t.vertex_i_x = cx;
			t.vertex_i_y = cx;
			t.vertex_j_x = cx + 65536;
			t.vertex_j_y = cx + 65536;
			t.vertex_k_x = cx + 131072 + $urandom_range(0, 3) - 1;
			t.vertex_k_y = cx + 131072 + $urandom_range(0, 3) - 1;
		end else if (mode == 9) begin
			if ($urandom_range(0, 1)) begin
				t.side_i_length = '0;
				t.side_j_length = '0;
				t.side_k_length = '0;
			end else begin
				t.side_i_length = '1;
				t.side_j_length = '1;
				t.side_k_length = '1;
			end
		end
		return t;
	endfunction

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tri_valid <= 1'b0;
			tri_data <= '0;
		end else if (!tri_valid || !tri_stall) begin
			if (tri_valid) begin
				expected_results.push_back(predict_circles(tri_data));
				sent_count++;
			end
			if (gap_left == 0 && pending_tris.size() > 0 &&
					!(sent_count == PAUSE_AT && (expected_results.size() > 0 || tri_valid))) begin
				tri_valid <= 1'b1;
				tri_data <= pending_tris.pop_front();
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				tri_valid <= 1'b0;
				if (gap_left > 0) gap_left--;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		tci_out_t e;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			cycle_count++;
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no triangle outstanding");
					failures++;
				end else begin
					e = expected_results.pop_front();
					check_field("result_index", 64'(e.result_index),
						64'(res_data.result_index));
					check_field("circum_valid", 64'(e.circum_valid),
						64'(res_data.circum_valid));
					check_field("circumcenter_x", 64'(e.circumcenter_x),
						64'(res_data.circumcenter_x));
					check_field("circumcenter_y", 64'(e.circumcenter_y),
						64'(res_data.circumcenter_y));
					check_field("circum_radius", 64'(e.circum_radius),
						64'(res_data.circum_radius));
					check_field("doubled_area", e.doubled_area, res_data.doubled_area);
					check_field("in_valid", 64'(e.in_valid), 64'(res_data.in_valid));
					check_field("incenter_x", 64'(e.incenter_x), 64'(res_data.incenter_x));
					check_field("incenter_y", 64'(e.incenter_y), 64'(res_data.incenter_y));
					check_field("in_radius", 64'(e.in_radius), 64'(res_data.in_radius));
				end
			end
			if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 3);
			if (cycle_count >= HOLD_START && cycle_count < HOLD_START + HOLD_LEN)
				res_stall <= 1'b1;
			else if (stall_mode == 0)
				res_stall <= 1'b0;
			else if (stall_mode == 1)
				res_stall <= ($urandom_range(0, 9) < 3);
			else if (stall_mode == 2)
				res_stall <= ($urandom_range(0, 9) < 7);
			else
				res_stall <= (cycle_count % 5 == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((tri_valid && !tri_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_tris.push_back(make_tri(0, 0, 65536, 0, 0, 65536, 92682, 65536, 65536));
		pending_tris.push_back(make_tri(0, 0, 0, 65536, 65536, 0, 92682, 65536, 65536));
		pending_tris.push_back(make_tri(0, 0, 65536, 65536, 131072, 131072, 1, 2, 3));
		pending_tris.push_back(make_tri(0, 0, 65536, 65536, 131072, 131073, 1, 0, 0));
		pending_tris.push_back(make_tri(-2147483648, -2147483648, 2147483647, -2147483648,
			-2147483648, 2147483647, '1, '1, '1));
		pending_tris.push_back(make_tri(-2147483648, -2147483648, -2147483648, 2147483647,
			2147483647, -2147483648, '1, '1, '1));
		pending_tris.push_back(make_tri(2147483647, 2147483647, 2147483647, 2147483647,
			2147483647, 2147483647, '1, 0, 0));
		pending_tris.push_back(make_tri(-2147483648, -2147483648, -2147483648, -2147483648,
			-2147483648, -2147483648, 0, 0, '1));
		pending_tris.push_back(make_tri(-2147483648, 0, 2147483647, 0, 0, 1, 0, '1, 0));
		pending_tris.push_back(make_tri(0, 0, 3, 0, 0, 3, 1, 1, 1));
		pending_tris.push_back(make_tri(0, 0, 1, 0, 0, 1, 0, 0, 1));
		pending_tris.push_back(make_tri(100, -50, 300, 20, -40, 700, 5, 7, 9));
		pending_tris.push_back(make_tri(2147483647, -2147483648, -2147483648, 2147483647,
			2147483647, 2147483647, 1, 1, 1));
		for (int i = 0; i < N_RANDOM; i++) pending_tris.push_back(random_tri());
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_tris.size() == 0);
		@(posedge clk);
		while (tri_valid) @(posedge clk);
		while (expected_results.size() > 0) @(posedge clk);
		repeat (PIPE_LAT + 20) @(posedge clk);
		if (failures == 0 && expected_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
